[hw/rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum
// Word layouts of the sample and result channels, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;

  localparam int CFG_W    = 7;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 32;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_value;
    logic [COUNT_W-1:0]         result_number;
  } out_word_t;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_maximum.sv]
// ----------------------------------------------------------------------------
// sliding_window_maximum: maximum over the last window_size signed samples
// A row of cells keeps, in cell k, the maximum of the live samples among the
// last k+1; the cell picked by the window length gives the result, and the
// cells past the window take that value so aged-out samples never return.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          word
//   in       in   in_valid/in_stall  in_word  (sample, last_sample)
//   out      out  out_valid/out_stall out_word (max_value, result_number)
//   cfg      in   cfg_valid/cfg_ready cfg_data (window_size)
//
// One sample per cycle while in_stall is low; its result shows in the cycle after it is accepted.
// Every cell updates in the cycle of the accept: one compare per cell, then
// the window-length select over the row, which also feeds the cells past the
// window, sets the cycle.
// Reset is synchronous; afterwards window_size is 1 and the sequence is empty.
// in_stall follows out_stall only while a result is waiting in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  swm_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  wire                           out_stall,
  output swm_pkg::out_word_t            out_word,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [swm_pkg::CFG_W-1:0]      cfg_data
);

  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SEEN_W = $clog2(WINDOW_MAX + 1);
  localparam logic [swm_pkg::COUNT_W-1:0] COUNT_SAT = '1;

  logic [swm_pkg::CFG_W-1:0]    win_r;
  logic [SEEN_W-1:0]            seen_r;
  logic [SEEN_W-1:0]            seen_nxt;
  logic [swm_pkg::COUNT_W-1:0]  results_r;
  logic [swm_pkg::COUNT_W-1:0]  results_nxt;
  logic                         out_valid_r;
  swm_pkg::out_word_t           out_word_r;

  logic [31:0]                  win_ext;
  logic [31:0]                  win_eff32;
  logic [SEEN_W-1:0]            win_eff;
  logic [IDX_W-1:0]             sel;
  logic                         in_accept;
  logic                         due;
  swm_pkg::sample_t             win_max;

  swm_pkg::sample_t cell_nxt [WINDOW_MAX];
  swm_pkg::sample_t cell_q   [WINDOW_MAX];

  // Cell chain
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    swm_pkg::sample_t prev;
    logic             in_win;
    if (k == 0) begin : g_head
      assign prev = in_word.sample;
    end else begin : g_body
      assign prev = cell_q[k-1];
    end
    assign in_win = (SEEN_W'(k) < win_eff);
    swm_cell u_cell (
      .clk       (clk),
      .shift     (in_accept),
      .in_window (in_win),
      .sample    (in_word.sample),
      .prev      (prev),
      .fill      (win_max),
      .max_nxt   (cell_nxt[k]),
      .max_q     (cell_q[k])
    );
  end

  // Clamp window length to 1..WINDOW_MAX
  assign win_ext   = 32'(win_r);
  assign win_eff32 = (win_ext == 32'd0) ? 32'd1 :
                     (win_ext > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : win_ext;
  assign win_eff   = SEEN_W'(win_eff32);
  assign sel       = IDX_W'(win_eff32 - 32'd1);
  assign win_max   = cell_nxt[sel];

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign seen_nxt    = (seen_r == SEEN_W'(WINDOW_MAX)) ? seen_r : seen_r + SEEN_W'(1);
  assign due         = (seen_nxt >= win_eff);
  assign results_nxt = (results_r == COUNT_SAT) ? results_r
                                                : results_r + swm_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= swm_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      results_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= due;
      if (in_word.last_sample) begin
        // drop the sequence once its last word is through
        seen_r    <= '0;
        results_r <= '0;
      end else begin
        seen_r <= seen_nxt;
        if (due) begin
          results_r <= results_nxt;
        end
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && due) begin
      out_word_r.max_value     <= win_max;
      out_word_r.result_number <= results_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A due result appears in the output register right after the accept
  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && due |=> out_valid)
    else $error("due result not presented");

  // Result numbers start at one
  a_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.result_number != '0)
    else $error("result number zero");

  // The sequence counters clear after a last word
  a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_word.last_sample |=> seen_r == '0 && results_r == '0)
    else $error("sequence not cleared");

  // No more results than samples in the sequence
  a_results_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != SEEN_W'(WINDOW_MAX) |-> results_r <= swm_pkg::COUNT_W'(seen_r))
    else $error("result count exceeds sample count");

endmodule

`default_nettype wire

[hw/rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one cell of the running maximum chain
// Holds the maximum of the live samples of age 0..k. On a shift, a cell inside
// the window takes the larger of the new sample and its neighbor's old
// maximum. A cell past the window takes the window maximum, so samples that
// have aged out stay out when the window grows later.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
  input  wire               clk,
  input  wire               shift,
  input  wire               in_window,
  input  swm_pkg::sample_t  sample,
  input  swm_pkg::sample_t  prev,
  input  swm_pkg::sample_t  fill,
  output swm_pkg::sample_t  max_nxt,
  output swm_pkg::sample_t  max_q
);

  swm_pkg::sample_t max_r;

  assign max_nxt = (sample > prev) ? sample : prev;
  assign max_q   = max_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      max_r <= in_window ? max_nxt : fill;
    end
  end

endmodule

`default_nettype wire
